>>> rtl/ufd_pkg.sv
package ufd_pkg;

  localparam int unsigned HEADER_BYTES = 7;
  localparam int unsigned ACK_BYTES    = 8;
  localparam int unsigned POS_W        = 17;
  localparam int unsigned STEP_W       = $clog2(ACK_BYTES + 1);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ACK_TYPE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ACK_TYPE = 8'd3;

  localparam logic [7:0] SYNC_FIRST_RST    = 8'hA5;
  localparam logic [7:0] SYNC_SECOND_RST   = 8'h01;
  localparam logic [7:0] OWN_ACK_TYPE_RST  = 8'h03;
  localparam logic [7:0] PEER_ACK_TYPE_RST = 8'hFF;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_FRAME_END = 2'd1;
  localparam logic [1:0] KIND_ACK       = 2'd2;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_PAYLOAD   = 2'd0,
    CMD_END_NOACK = 2'd1,
    CMD_END_ACK   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [7:0]  ftype;
    logic [15:0] fid;
    logic [15:0] flen;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] own_ack_type;
    logic [7:0] peer_ack_type;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

>>> rtl/ufd_front.sv
module ufd_front (
  input  logic               clk,
  input  logic               rst,
  input  ufd_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic [7:0]         rx_byte,
  input  ufd_pkg::q_status_t q_status,
  output logic               push,
  output ufd_pkg::cmd_t      cmd
);

  ufd_pkg::phase_t                 phase, phase_next;
  logic [ufd_pkg::POS_W-1:0]       pos, pos_next;
  logic [7:0]                      type_reg, type_reg_next;
  logic [15:0]                     length_reg, length_reg_next;
  logic [15:0]                     id_reg, id_reg_next;
  logic [ufd_pkg::POS_W-1:0]       final_pos;
  logic                            accept;
  logic                            no_ack;

  assign accept    = in_valid && !q_status.full;
  assign final_pos = {1'b0, length_reg} + ufd_pkg::POS_W'(ufd_pkg::HEADER_BYTES);
  assign no_ack    = (type_reg == cfg.own_ack_type) || (type_reg == cfg.peer_ack_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ufd_pkg::PH_HUNT1;
      pos        <= '0;
      type_reg   <= '0;
      length_reg <= '0;
      id_reg     <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      type_reg   <= type_reg_next;
      length_reg <= length_reg_next;
      id_reg     <= id_reg_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    type_reg_next   = type_reg;
    length_reg_next = length_reg;
    id_reg_next     = id_reg;
    push            = 1'b0;
    cmd.kind        = ufd_pkg::CMD_PAYLOAD;
    cmd.data        = rx_byte;
    cmd.ftype       = type_reg;
    cmd.fid         = id_reg;
    cmd.flen        = length_reg;
    if (accept) begin
      unique case (phase)
        ufd_pkg::PH_HUNT2: begin
          // a bad second sync byte is never reused as a first one
          if (rx_byte == cfg.sync_second) begin
            phase_next = ufd_pkg::PH_FRAME;
            pos_next   = ufd_pkg::POS_W'(2);
          end else begin
            phase_next = ufd_pkg::PH_HUNT1;
            pos_next   = '0;
          end
        end
        ufd_pkg::PH_FRAME: begin
          if (pos < ufd_pkg::POS_W'(ufd_pkg::HEADER_BYTES)) begin
            if (pos == ufd_pkg::POS_W'(2)) type_reg_next = rx_byte;
            if (pos == ufd_pkg::POS_W'(3)) length_reg_next[7:0] = rx_byte;
            if (pos == ufd_pkg::POS_W'(4)) length_reg_next[15:8] = rx_byte;
            if (pos == ufd_pkg::POS_W'(5)) id_reg_next[7:0] = rx_byte;
            if (pos == ufd_pkg::POS_W'(6)) id_reg_next[15:8] = rx_byte;
            pos_next = pos + 1'b1;
          end else if (pos < final_pos) begin
            pos_next = pos + 1'b1;
            push     = 1'b1;
          end else begin
            phase_next = ufd_pkg::PH_HUNT1;
            pos_next   = '0;
            push       = 1'b1;
            cmd.kind   = no_ack ? ufd_pkg::CMD_END_NOACK : ufd_pkg::CMD_END_ACK;
          end
        end
        default: begin
          if (rx_byte == cfg.sync_first) begin
            phase_next = ufd_pkg::PH_HUNT2;
            pos_next   = ufd_pkg::POS_W'(1);
          end else begin
            phase_next = ufd_pkg::PH_HUNT1;
            pos_next   = '0;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/ufd_queue.sv
module ufd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ufd_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output ufd_pkg::cmd_t      head,
  output ufd_pkg::q_status_t status
);

  ufd_pkg::cmd_t                mem [ufd_pkg::QDEPTH];
  logic [ufd_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [ufd_pkg::QCNT_W-1:0]   count;
  logic                         do_push, do_pop;

  assign status.full  = (count == ufd_pkg::QCNT_W'(ufd_pkg::QDEPTH));
  assign status.valid = (count != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ufd_pkg::QPTR_W'(ufd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ufd_pkg::QPTR_W'(ufd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/ufd_back.sv
module ufd_back (
  input  logic               clk,
  input  logic               rst,
  input  ufd_pkg::cfg_t      cfg,
  input  ufd_pkg::cmd_t      head,
  input  ufd_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         data,
  output logic [7:0]         frame_type,
  output logic [15:0]        frame_id,
  output logic [15:0]        frame_length,
  output logic               last
);

  logic [ufd_pkg::STEP_W-1:0] step;
  logic                       load;
  logic                       last_step;
  logic [1:0]                 kind_next;
  logic [7:0]                 data_next;
  logic [7:0]                 ack_sum;
  logic [7:0]                 ack_byte;

  assign load = !out_valid || !out_stall;
  assign last_step = (head.kind != ufd_pkg::CMD_END_ACK) ||
                     (step == ufd_pkg::STEP_W'(ufd_pkg::ACK_BYTES));
  assign pop = load && q_status.valid && last_step;

  assign ack_sum = cfg.sync_first + cfg.sync_second + cfg.own_ack_type +
                   head.fid[7:0] + head.fid[15:8];

  // step 1..8 walks the ack word: sync, sync, type, 0, 0, id lo, id hi, check
  always_comb begin
    unique case (step)
      ufd_pkg::STEP_W'(1): ack_byte = cfg.sync_first;
      ufd_pkg::STEP_W'(2): ack_byte = cfg.sync_second;
      ufd_pkg::STEP_W'(3): ack_byte = cfg.own_ack_type;
      ufd_pkg::STEP_W'(6): ack_byte = head.fid[7:0];
      ufd_pkg::STEP_W'(7): ack_byte = head.fid[15:8];
      ufd_pkg::STEP_W'(8): ack_byte = 8'd0 - ack_sum;
      default:             ack_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (head.kind)
      ufd_pkg::CMD_PAYLOAD: begin
        kind_next = ufd_pkg::KIND_PAYLOAD;
        data_next = head.data;
      end
      ufd_pkg::CMD_END_NOACK: begin
        kind_next = ufd_pkg::KIND_FRAME_END;
        data_next = head.data;
      end
      default: begin
        kind_next = (step == '0) ? ufd_pkg::KIND_FRAME_END : ufd_pkg::KIND_ACK;
        data_next = (step == '0) ? head.data : ack_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= q_status.valid;
      if (q_status.valid) begin
        step <= last_step ? '0 : step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_status.valid) begin
      kind         <= kind_next;
      data         <= data_next;
      frame_type   <= head.ftype;
      frame_id     <= head.fid;
      frame_length <= head.flen;
      last         <= last_step;
    end
  end

endmodule

>>> rtl/uart_frame_deframer_with_ack_unit.sv
// A payload byte passes the command queue and the output register before it shows.
// Throughput: one byte per cycle unless a stall holds it; header bytes give no word.
// A frame end with an ack drains 9 words, one a cycle unless out_stall is high,
// from a 2-entry command queue; input stalls once that queue is full.
// Reset (rst, synchronous): hunting for the first sync byte, queue and output
// empty, registers back to A5/01/03/FF.
module uart_frame_deframer_with_ack_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      kind,
  output logic [7:0]                      data,
  output logic [7:0]                      frame_type,
  output logic [15:0]                     frame_id,
  output logic [15:0]                     frame_length,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ufd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);

  ufd_pkg::cfg_t      cfg;
  ufd_pkg::cmd_t      push_cmd;
  ufd_pkg::cmd_t      head;
  ufd_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= ufd_pkg::SYNC_FIRST_RST;
      cfg.sync_second   <= ufd_pkg::SYNC_SECOND_RST;
      cfg.own_ack_type  <= ufd_pkg::OWN_ACK_TYPE_RST;
      cfg.peer_ack_type <= ufd_pkg::PEER_ACK_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ufd_pkg::CFG_SYNC_FIRST:    cfg.sync_first    <= cfg_data;
        ufd_pkg::CFG_SYNC_SECOND:   cfg.sync_second   <= cfg_data;
        ufd_pkg::CFG_OWN_ACK_TYPE:  cfg.own_ack_type  <= cfg_data;
        ufd_pkg::CFG_PEER_ACK_TYPE: cfg.peer_ack_type <= cfg_data;
        default: ;
      endcase
    end
  end

  ufd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  ufd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ufd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data         (data),
    .frame_type   (frame_type),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .last         (last)
  );

endmodule

>>> rtl/ufd_checker.sv
module ufd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic       last
);

  // nothing comes out the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind != ufd_pkg::KIND_UNUSED))
    else $error("unused kind code on output");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == ufd_pkg::KIND_PAYLOAD) |-> last)
    else $error("payload word without last");

  // a frame end that is not last and not stalled is followed at once by the ack burst
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && kind == ufd_pkg::KIND_FRAME_END && !last)
    |=> (out_valid && kind == ufd_pkg::KIND_ACK))
    else $error("ack burst does not follow frame end");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && kind == ufd_pkg::KIND_ACK && !last)
    |=> (out_valid && kind == ufd_pkg::KIND_ACK))
    else $error("ack burst broken");

endmodule

bind uart_frame_deframer_with_ack_unit ufd_checker u_ufd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .last      (last)
);
